// ===== rtl/sfr_pkg.sv =====
// shared types and constants of the sync frame receiver
`default_nettype none
package sfr_pkg;

  typedef logic [7:0] byte_t;

  // header, four data bytes, checksum, trailer
  localparam int unsigned FrameLen  = 7;
  localparam int unsigned StoredLen = FrameLen - 1;
  localparam int unsigned CountW    = $clog2(FrameLen);

  typedef logic [1:0] status_t;
  localparam status_t StValid      = 2'd0;
  localparam status_t StBadSum     = 2'd1;
  localparam status_t StBadTrailer = 2'd2;

  localparam int unsigned CfgIndexW = 8;
  localparam logic [CfgIndexW-1:0] RegHeader  = 8'd0;
  localparam logic [CfgIndexW-1:0] RegTrailer = 8'd1;

  localparam byte_t HeaderReset  = 8'hAA;
  localparam byte_t TrailerReset = 8'hFF;

  // result item: frame_status, reading, padded to whole bytes
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic  shift;
    byte_t data;
  } cell_link_t;

endpackage
`default_nettype wire

// ===== rtl/sfr_cell.sv =====
// one byte stage of the frame shift chain
`default_nettype none
module sfr_cell (
  input  wire               clk,
  input  wire sfr_pkg::cell_link_t link_in,
  output sfr_pkg::cell_link_t link_out
);

  sfr_pkg::byte_t data_r;
  sfr_pkg::byte_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (link_in.shift) begin
      data_nxt = link_in.data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // pass the shift enable along with what this stage held
  assign link_out.shift = link_in.shift;
  assign link_out.data  = data_r;

endmodule
`default_nettype wire

// ===== rtl/sync_frame_receiver.sv =====
// sync frame receiver: the result item is registered in the cycle after the seventh byte is accepted
// throughput one byte item per cycle; in_tready drops only while a result waits
// and out_tready is low
// rst_n is synchronous, active low: idle, held reading zero, registers to 0xAA/0xFF
// frame bytes shift through a row of six byte cells and are not reset
`default_nettype none
module sync_frame_receiver (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: rx_byte[7:0]
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,
  // out_tdata: frame_status[1:0], reading[17:2], zero[23:18]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [sfr_pkg::OutDataW-1:0] out_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [sfr_pkg::CfgIndexW-1:0] cfg_index,
  input  wire  [7:0]  cfg_data
);

  localparam int unsigned N = sfr_pkg::StoredLen;

  sfr_pkg::byte_t header_r, trailer_r;
  logic collecting_r, collecting_nxt;
  logic [sfr_pkg::CountW-1:0] count_r, count_nxt;
  logic [15:0] held_r, held_nxt;
  logic out_valid_r, out_valid_nxt;
  sfr_pkg::status_t out_status_r, out_status_nxt;
  logic [15:0] out_reading_r, out_reading_nxt;

  logic accept, shift, closing;
  sfr_pkg::cell_link_t link [N+1];
  sfr_pkg::byte_t cell_q [N];
  logic [9:0] sum_wide;
  sfr_pkg::byte_t sum8;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign closing = accept && collecting_r &&
                   (count_r == sfr_pkg::CountW'(sfr_pkg::StoredLen));
  assign shift   = accept && !closing &&
                   (collecting_r || (in_tdata == header_r));

  assign link[0].shift = shift;
  assign link[0].data  = in_tdata;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sfr_cell u_cell (
      .clk      (clk),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
    assign cell_q[i] = link[i+1].data;
  end

  // once six bytes are in, cell 0 holds the checksum and cell 5 the header
  assign sum_wide = {2'b00, cell_q[1]} + {2'b00, cell_q[2]} +
                    {2'b00, cell_q[3]} + {2'b00, cell_q[4]};
  assign sum8     = sum_wide[7:0];

  always_comb begin
    collecting_nxt  = collecting_r;
    count_nxt       = count_r;
    held_nxt        = held_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_reading_nxt = out_reading_r;
    if (shift) begin
      collecting_nxt = 1'b1;
      count_nxt      = count_r + 1'b1;
    end
    if (closing) begin
      collecting_nxt = 1'b0;
      count_nxt      = '0;
      out_valid_nxt  = 1'b1;
      if (in_tdata != trailer_r) begin
        out_status_nxt  = sfr_pkg::StBadTrailer;
        out_reading_nxt = held_r;
      end else if (sum8 == cell_q[0]) begin
        held_nxt        = {cell_q[4], cell_q[3]};
        out_status_nxt  = sfr_pkg::StValid;
        out_reading_nxt = {cell_q[4], cell_q[3]};
      end else begin
        out_status_nxt  = sfr_pkg::StBadSum;
        out_reading_nxt = held_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r     <= sfr_pkg::HeaderReset;
      trailer_r    <= sfr_pkg::TrailerReset;
      collecting_r <= 1'b0;
      count_r      <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfr_pkg::RegHeader:  header_r  <= cfg_data;
          sfr_pkg::RegTrailer: trailer_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_reading_r <= out_reading_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_reading_r, out_status_r};

endmodule
`default_nettype wire

// ===== rtl/sfr_checker.sv =====
// port-level checks of the sync frame receiver and their bind
`default_nettype none
module sfr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [sfr_pkg::OutDataW-1:0] out_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // no result follows reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item shown straight after reset");

  // input stalls only behind a waiting result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with result path free");

  // status is one of the three defined codes, padding is zero
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= sfr_pkg::StBadTrailer && out_tdata[23:18] == 6'd0)
    else $error("bad status code or padding");

endmodule

bind sync_frame_receiver sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== tb/sync_frame_receiver_tb.sv =====
// self-checking testbench for the sync frame receiver
`default_nettype none
module sync_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned SettleCycles = 4;

  typedef enum logic [1:0] {RxAlways, RxMostly, RxPattern, RxCoin} rx_mode_t;

  typedef struct packed {
    sfr_pkg::status_t status;
    logic [15:0]      reading;
  } frame_res_t;

  // tracks the parser state and holds the frame results still owed by the block
  class frame_scoreboard;
    sfr_pkg::byte_t hdr;
    sfr_pkg::byte_t trl;
    bit             active;
    int unsigned    cnt;
    sfr_pkg::byte_t body [sfr_pkg::StoredLen];
    logic [15:0]    held;
    frame_res_t     due [$];
    int unsigned    errors;

    function new();
      hdr    = sfr_pkg::HeaderReset;
      trl    = sfr_pkg::TrailerReset;
      active = 1'b0;
      cnt    = 0;
      held   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [sfr_pkg::CfgIndexW-1:0] idx, sfr_pkg::byte_t v);
      if (idx == sfr_pkg::RegHeader) hdr = v;
      else if (idx == sfr_pkg::RegTrailer) trl = v;
    endfunction

    // returns 1 when the byte belongs to a frame, 0 when the idle parser drops it
    function bit note_byte(sfr_pkg::byte_t b);
      sfr_pkg::byte_t   sum;
      sfr_pkg::status_t st;
      if (!active) begin
        if (b != hdr) return 1'b0;
        active = 1'b1;
        cnt    = 0;
      end
      if (cnt < sfr_pkg::StoredLen) begin
        body[cnt] = b;
        cnt++;
        return 1'b1;
      end
      active = 1'b0;
      cnt    = 0;
      // checksum is only looked at once the trailer is right
      if (b != trl) begin
        st = sfr_pkg::StBadTrailer;
      end else begin
        sum = body[1] + body[2] + body[3] + body[4];
        if (sum == body[5]) begin
          held = {body[1], body[2]};
          st   = sfr_pkg::StValid;
        end else begin
          st = sfr_pkg::StBadSum;
        end
      end
      due.push_back('{st, held});
      return 1'b1;
    endfunction

    function void check_result(logic [sfr_pkg::OutDataW-1:0] d);
      frame_res_t want;
      if (due.size() == 0) begin
        $error("result item with nothing expected: frame_status %0d reading %0h",
               d[1:0], d[17:2]);
        errors++;
        return;
      end
      want = due.pop_front();
      if (d[1:0] !== want.status) begin
        $error("frame_status: expected %0d, actual %0d", want.status, d[1:0]);
        errors++;
      end
      if (d[17:2] !== want.reading) begin
        $error("reading: expected %0h, actual %0h", want.reading, d[17:2]);
        errors++;
      end
      if (d[sfr_pkg::OutDataW-1:18] !== '0) begin
        $error("padding: expected 0, actual %0h", d[sfr_pkg::OutDataW-1:18]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [sfr_pkg::OutDataW-1:0]  out_tdata;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [sfr_pkg::CfgIndexW-1:0] cfg_index  = '0;
  logic [7:0]                    cfg_data   = '0;

  frame_scoreboard sb;
  int unsigned     used_items  = 0;
  int unsigned     burst_left  = 0;
  int unsigned     gap_max     = 0;
  int unsigned     cycles      = 0;
  rx_mode_t        stall_mode  = RxAlways;
  logic            hold_go     = 1'b0;
  bit              hold_done   = 1'b0;
  int unsigned     hold_left   = 0;
  int unsigned     ready_phase = 0;

  // first result still carries the reset reading, then extremes and a header inside a frame
  sfr_pkg::byte_t directed_seq [29] = '{
    8'h55,
    8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
    8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC, 8'hFF,
    8'hAA, 8'hAA, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hFF,
    8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sync_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("sync_frame_receiver verification failed");
      $finish;
    end
  end

  // result side: check accepted items, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    ready_phase++;
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        RxAlways:  out_tready <= 1'b1;
        RxMostly:  out_tready <= ($urandom_range(0, 3) != 0);
        RxPattern: out_tready <= ((ready_phase % 7) < 3);
        default:   out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic send_byte(input sfr_pkg::byte_t b);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (sb.note_byte(b)) used_items++;
    burst_left--;
  endtask

  // sender stops until every owed result has come out and the block has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one write to an unused index, then both registers
  task automatic set_regs(input logic [sfr_pkg::CfgIndexW-1:0] junk_idx,
                          input sfr_pkg::byte_t junk_val,
                          input sfr_pkg::byte_t hdr, input sfr_pkg::byte_t trl);
    logic [sfr_pkg::CfgIndexW-1:0] idx [3];
    sfr_pkg::byte_t                val [3];
    idx = '{junk_idx, sfr_pkg::RegHeader, sfr_pkg::RegTrailer};
    val = '{junk_val, hdr, trl};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic sfr_pkg::byte_t data_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // a well-formed frame most of the time, else line noise or a damaged frame
  task automatic send_random_unit();
    sfr_pkg::byte_t frame [sfr_pkg::FrameLen];
    int unsigned    kind;
    int unsigned    len;
    sfr_pkg::byte_t noise;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) begin
        noise = 8'($urandom);
        if (noise == sb.hdr) noise ^= 8'h01;
        send_byte(noise);
      end
      return;
    end
    frame[0] = sb.hdr;
    for (int i = 1; i <= 4; i++) frame[i] = data_byte();
    frame[5] = frame[1] + frame[2] + frame[3] + frame[4];
    frame[6] = sb.trl;
    len = sfr_pkg::FrameLen;
    if (kind < 14) len = $urandom_range(2, sfr_pkg::FrameLen - 1);
    else if (kind < 26) frame[5] ^= 8'($urandom_range(1, 255));
    else if (kind < 36) begin
      frame[6] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(0, 2) == 0) frame[5] ^= 8'($urandom_range(1, 255));
    end else if (kind < 40) wait_idle();
    for (int i = 0; i < len; i++) send_byte(frame[i]);
  endtask

  task automatic run_phase(input logic [sfr_pkg::CfgIndexW-1:0] junk_idx,
                           input sfr_pkg::byte_t junk_val,
                           input sfr_pkg::byte_t hdr, input sfr_pkg::byte_t trl,
                           input int unsigned gaps, input rx_mode_t mode,
                           input int unsigned count, input bit hold);
    int unsigned target;
    set_regs(junk_idx, junk_val, hdr, trl);
    gap_max    = gaps;
    stall_mode <= mode;
    // receiver holds off while frames keep coming, so the input side backs up
    if (hold) hold_go <= 1'b1;
    target = used_items + count;
    while (used_items < target) send_random_unit();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    gap_max    = 3;
    stall_mode <= RxMostly;
    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    run_phase(8'hC3, 8'h00, 8'h00, 8'h00, 0, RxAlways, 100, 1'b0);
    run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 4, RxMostly, 100, 1'b1);
    run_phase(8'h02, 8'($urandom), 8'($urandom), 8'($urandom), 8, RxPattern, 100, 1'b0);
    run_phase(8'($urandom_range(2, 255)), 8'($urandom), 8'($urandom), 8'($urandom),
              2, RxCoin, 100, 1'b0);
    run_phase(8'h7E, 8'h81, sfr_pkg::HeaderReset, sfr_pkg::TrailerReset, 6, RxMostly,
              100, 1'b0);

    wait_idle();
    if (sb.errors == 0) begin
      $display("sync_frame_receiver verification clean");
    end else begin
      $display("sync_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
